/* rtl/cwtc_pkg.sv */
// Shared types, constants and helpers for the codepoint window text chunker.
`timescale 1ns / 1ps
package cwtc_pkg;

	localparam int MAX_BUDGET     = 256;
	localparam int WIN_DEPTH      = MAX_BUDGET + 1;
	localparam int BUDGET_RESET   = 64;
	localparam int OQ_DEPTH       = 4;

	typedef enum logic [1:0] {
		CLS_OTHER  = 2'd0,
		CLS_SPACE  = 2'd1,
		CLS_SENT   = 2'd2,
		CLS_CLAUSE = 2'd3
	} cls_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_BAD_LEAD  = 3'd1,
		ERR_BAD_CONT  = 3'd2,
		ERR_TRUNC     = 3'd3,
		ERR_TOO_LONG  = 3'd4
	} err_t;

	typedef enum logic [3:0] {
		E_IDLE,
		E_EVENT,
		E_SRCH_RD,
		E_SRCH_CK,
		E_TRIM_RD,
		E_TRIM_CK,
		E_START_RD,
		E_START_CK,
		E_LEAD_RD,
		E_LEAD_CK,
		E_LASTCHK
	} eng_state_t;

	typedef struct packed {
		logic [16:0] start;
		logic [2:0]  len;
		cls_t        cls;
	} entry_t;

	typedef struct packed {
		logic        act;
		logic        have_cp;
		logic        last;
		err_t        err;
		logic [16:0] start;
		logic [2:0]  len;
		cls_t        cls;
	} ev_t;

	typedef struct packed {
		logic [15:0] span_start;
		logic [16:0] span_end;
		logic        chunk_valid;
		logic        final_result;
		logic [2:0]  error_code;
	} res_t;

	function automatic logic is_space(input logic [20:0] b);
		return (b == 21'h20) || (b >= 21'h09 && b <= 21'h0D);
	endfunction

	function automatic cls_t class_of(input logic [20:0] cp, input logic [2:0] len);
		cls_t c;
		c = CLS_OTHER;
		if (len == 3'd1) begin
			if (is_space(cp)) c = CLS_SPACE;
			else if (cp == 21'h2E || cp == 21'h21 || cp == 21'h3F) c = CLS_SENT;
			else if (cp == 21'h2C || cp == 21'h3B || cp == 21'h3A) c = CLS_CLAUSE;
		end else if (len == 3'd3) begin
			if (cp == 21'h3002 || cp == 21'hFF01 || cp == 21'hFF1F) c = CLS_SENT;
			else if (cp == 21'hFF0C || cp == 21'h3001 || cp == 21'hFF1B || cp == 21'hFF1A)
				c = CLS_CLAUSE;
		end
		return c;
	endfunction

	// Ring index head + k modulo the window depth.
	function automatic logic [8:0] ring_add(input logic [8:0] head, input logic [8:0] k);
		logic [9:0] s;
		s = {1'b0, head} + {1'b0, k};
		if (s >= 10'(WIN_DEPTH)) s = s - 10'(WIN_DEPTH);
		return s[8:0];
	endfunction

endpackage

/* rtl/cwtc_if.sv */
// Handshake channel interfaces: text input, chunk output, budget write.
`timescale 1ns / 1ps
interface cwtc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;
	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface cwtc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] span_start;
	logic [16:0] span_end;
	logic        chunk_valid;
	logic        final_result;
	logic [2:0]  error_code;
	modport source (output valid, output span_start, output span_end, output chunk_valid,
		output final_result, output error_code, input ready);
	modport sink (input valid, input span_start, input span_end, input chunk_valid,
		input final_result, input error_code, output ready);
endinterface

interface cwtc_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] cp_limit;
	modport source (output valid, output cp_limit, input ready);
	modport sink (input valid, input cp_limit, output ready);
endinterface

/* rtl/cwtc_decode.sv */
// UTF-8 decoder: byte offsets, sequence tracking and error detection.
`timescale 1ns / 1ps
module cwtc_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     text_byte,
	input  logic           end_of_text,
	output cwtc_pkg::ev_t  ev
);
	import cwtc_pkg::*;

	logic [16:0] offset_q, offset_n;
	logic [20:0] pend_q, pend_n, cp;
	logic [1:0]  cont_q, cont_n;
	logic [16:0] lead_q, lead_n;
	logic        drop_q, broken_q, broken_n;
	logic [16:0] len_w;

	always_comb begin
		offset_n = offset_q;
		pend_n   = pend_q;
		cont_n   = cont_q;
		lead_n   = lead_q;
		broken_n = broken_q;
		cp       = pend_q;
		ev       = '0;
		ev.last  = end_of_text;
		ev.err   = ERR_NONE;
		ev.cls   = CLS_OTHER;
		if (!drop_q) begin
			ev.act = 1'b1;
			if (offset_q[16]) begin
				ev.err = ERR_TOO_LONG;
			end else begin
				offset_n = offset_q + 17'd1;
				if (broken_q && cont_q == 2'd0) begin
					if (!is_space({13'd0, text_byte})) ev.err = ERR_BAD_CONT;
				end else if (cont_q == 2'd0) begin
					lead_n = offset_q;
					if (text_byte <= 8'h7F) begin
						cp = {13'd0, text_byte};
						ev.have_cp = 1'b1;
					end else if ((text_byte & 8'hE0) == 8'hC0) begin
						pend_n = {16'd0, text_byte[4:0]};
						cont_n = 2'd1;
					end else if ((text_byte & 8'hF0) == 8'hE0) begin
						pend_n = {17'd0, text_byte[3:0]};
						cont_n = 2'd2;
					end else if ((text_byte & 8'hF8) == 8'hF0) begin
						pend_n = {18'd0, text_byte[2:0]};
						cont_n = 2'd3;
					end else begin
						ev.err = ERR_BAD_LEAD;
					end
				end else begin
					if (text_byte[7:6] != 2'b10) broken_n = 1'b1;
					else pend_n = {pend_q[14:0], text_byte[5:0]};
					cont_n = cont_q - 2'd1;
					if (cont_n == 2'd0) begin
						if (!broken_n) begin
							cp = pend_n;
							ev.have_cp = 1'b1;
						end else if (!is_space({13'd0, text_byte})) begin
							ev.err = ERR_BAD_CONT;
						end
					end
				end
				if (ev.err == ERR_NONE && end_of_text && (cont_n != 2'd0 || broken_n))
					ev.err = ERR_TRUNC;
			end
		end
		if (ev.err != ERR_NONE) ev.have_cp = 1'b0;
		if (ev.have_cp) pend_n = '0;
		len_w    = offset_n - lead_n;
		ev.start = lead_n;
		ev.len   = len_w[2:0];
		ev.cls   = class_of(cp, len_w[2:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			pend_q   <= '0;
			cont_q   <= '0;
			lead_q   <= '0;
			drop_q   <= 1'b0;
			broken_q <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				offset_q <= '0;
				pend_q   <= '0;
				cont_q   <= '0;
				lead_q   <= '0;
				drop_q   <= 1'b0;
				broken_q <= 1'b0;
			end else if (ev.act) begin
				offset_q <= offset_n;
				pend_q   <= pend_n;
				cont_q   <= cont_n;
				lead_q   <= lead_n;
				broken_q <= broken_n;
				if (ev.err != ERR_NONE) drop_q <= 1'b1;
			end
		end
	end

	// An error on a byte that is not the last always leaves the decoder dropping.
	a_err_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ev.err != ERR_NONE && !end_of_text |=> drop_q)
		else $error("error did not enter drop mode");
	// While dropping, bytes produce no action.
	a_drop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> !ev.act && !ev.have_cp)
		else $error("action while dropping");
	// A last byte always clears the text state.
	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_text |=> offset_q == 17'd0 && !drop_q && cont_q == 2'd0)
		else $error("text state not cleared");
endmodule

/* rtl/cwtc_outq.sv */
// Result queue between the chunk engine and the output channel.
`timescale 1ns / 1ps
module cwtc_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cwtc_pkg::res_t push_res,
	output logic [2:0]     count,
	cwtc_out_if.source     chunk_out
);
	import cwtc_pkg::*;

	res_t       mem_q [OQ_DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;
	logic       pop;
	res_t       head;

	assign pop   = chunk_out.valid && chunk_out.ready;
	assign count = count_q;
	assign head  = mem_q[rd_q];

	assign chunk_out.valid        = count_q != 3'd0;
	assign chunk_out.span_start   = head.span_start;
	assign chunk_out.span_end     = head.span_end;
	assign chunk_out.chunk_valid  = head.chunk_valid;
	assign chunk_out.final_result = head.final_result;
	assign chunk_out.error_code   = head.error_code;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			count_q <= count_q + {2'd0, push} - {2'd0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < 3'(OQ_DEPTH) || pop)
		else $error("result queue overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(OQ_DEPTH))
		else $error("result queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 3'(OQ_DEPTH) |-> (wr_q - rd_q) == count_q[1:0])
		else $error("queue pointers disagree with count");
endmodule

/* rtl/cwtc_engine.sv */
// Window engine: codepoint ring memory, backward break search, trim and flush.
`timescale 1ns / 1ps
module cwtc_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cwtc_pkg::ev_t   ev_in,
	input  logic [8:0]      budget_cfg,
	output logic            idle,
	output logic            push,
	output cwtc_pkg::res_t  push_res
);
	import cwtc_pkg::*;

	eng_state_t  state_q, state_n;
	ev_t         ev_q;
	entry_t      mem [WIN_DEPTH];
	entry_t      rd_q;
	logic [8:0]  head_q, count_q;
	logic [8:0]  idx_q, clause_q, end_q, k_q;
	logic [16:0] tend_q;
	logic        flush_q;
	logic [8:0]  budget;
	logic [8:0]  rd_rel, rd_addr, wr_addr;
	logic        wr_en;
	logic [8:0]  clause_w;

	always_comb begin
		if (budget_cfg == 9'd0) budget = 9'd1;
		else if (budget_cfg > 9'(MAX_BUDGET)) budget = 9'(MAX_BUDGET);
		else budget = budget_cfg;
	end

	assign idle = state_q == E_IDLE;
	assign clause_w = (rd_q.cls == CLS_CLAUSE && clause_q == 9'd0) ? idx_q : clause_q;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			E_IDLE: if (start) state_n = E_EVENT;
			E_EVENT: begin
				// dropped bytes after an error end here without a result
				if (!ev_q.act || ev_q.err != ERR_NONE) state_n = E_IDLE;
				else if (ev_q.have_cp && !(count_q == 9'd0 && ev_q.cls == CLS_SPACE)
						&& count_q + 9'd1 > budget)
					state_n = (budget > 9'd1) ? E_SRCH_RD : E_TRIM_RD;
				else state_n = E_LASTCHK;
			end
			E_SRCH_RD: state_n = E_SRCH_CK;
			E_SRCH_CK: begin
				if (rd_q.cls == CLS_SENT || idx_q - 9'd1 <= 9'd1) state_n = E_TRIM_RD;
				else state_n = E_SRCH_RD;
			end
			E_TRIM_RD: state_n = E_TRIM_CK;
			E_TRIM_CK: state_n = (k_q > 9'd1 && rd_q.cls == CLS_SPACE) ? E_TRIM_RD : E_START_RD;
			E_START_RD: state_n = E_START_CK;
			E_START_CK: begin
				if (flush_q) state_n = E_IDLE;
				else state_n = (count_q != end_q) ? E_LEAD_RD : E_LASTCHK;
			end
			E_LEAD_RD: state_n = E_LEAD_CK;
			E_LEAD_CK: begin
				if (rd_q.cls == CLS_SPACE && count_q > 9'd1) state_n = E_LEAD_RD;
				else state_n = E_LASTCHK;
			end
			E_LASTCHK: begin
				if (ev_q.last && count_q != 9'd0) state_n = E_TRIM_RD;
				else state_n = E_IDLE;
			end
			default: state_n = E_IDLE;
		endcase
	end

	// outputs: memory ports and result pushes
	always_comb begin
		push     = 1'b0;
		push_res = '0;
		wr_en    = 1'b0;
		wr_addr  = ring_add(head_q, count_q);
		rd_rel   = '0;
		case (state_q)
			E_EVENT: begin
				if (ev_q.err != ERR_NONE) begin
					push = 1'b1;
					push_res.final_result = 1'b1;
					push_res.error_code = ev_q.err;
				end else if (ev_q.have_cp && !(count_q == 9'd0 && ev_q.cls == CLS_SPACE)) begin
					wr_en = 1'b1;
				end
			end
			E_SRCH_RD: rd_rel = idx_q - 9'd1;
			E_TRIM_RD: rd_rel = k_q - 9'd1;
			E_START_CK: begin
				push = 1'b1;
				push_res.span_start   = rd_q.start[15:0];
				push_res.span_end     = tend_q;
				push_res.chunk_valid  = 1'b1;
				push_res.final_result = flush_q;
			end
			E_LASTCHK: begin
				if (ev_q.last && count_q == 9'd0) begin
					push = 1'b1;
					push_res.final_result = 1'b1;
				end
			end
			default: rd_rel = '0;
		endcase
		rd_addr = ring_add(head_q, rd_rel);
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= '{start: ev_q.start, len: ev_q.len, cls: ev_q.cls};
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			flush_q  <= 1'b0;
			ev_q     <= '0;
			idx_q    <= '0;
			clause_q <= '0;
			end_q    <= '0;
			k_q      <= '0;
			tend_q   <= '0;
		end else begin
			state_q <= state_n;
			case (state_q)
				E_IDLE: begin
					if (start) ev_q <= ev_in;
					flush_q <= 1'b0;
				end
				E_EVENT: begin
					// the rest of an errored text is dropped, so the window goes now
					if (ev_q.err != ERR_NONE) begin
						head_q  <= '0;
						count_q <= '0;
					end else if (wr_en) begin
						count_q  <= count_q + 9'd1;
						idx_q    <= budget;
						clause_q <= '0;
						end_q    <= budget;
						k_q      <= budget;
					end
				end
				E_SRCH_CK: begin
					clause_q <= clause_w;
					idx_q    <= idx_q - 9'd1;
					if (rd_q.cls == CLS_SENT) begin
						end_q <= idx_q;
						k_q   <= idx_q;
					end else if (idx_q - 9'd1 <= 9'd1) begin
						end_q <= (clause_w != 9'd0) ? clause_w : budget;
						k_q   <= (clause_w != 9'd0) ? clause_w : budget;
					end
				end
				E_TRIM_CK: begin
					if (k_q > 9'd1 && rd_q.cls == CLS_SPACE) k_q <= k_q - 9'd1;
					else tend_q <= rd_q.start + {14'd0, rd_q.len};
				end
				E_START_CK: begin
					if (flush_q) begin
						head_q  <= '0;
						count_q <= '0;
					end else begin
						head_q  <= ring_add(head_q, end_q);
						count_q <= count_q - end_q;
					end
				end
				E_LEAD_CK: begin
					if (rd_q.cls == CLS_SPACE) begin
						head_q  <= ring_add(head_q, 9'd1);
						count_q <= count_q - 9'd1;
					end
				end
				E_LASTCHK: begin
					if (ev_q.last) begin
						if (count_q != 9'd0) begin
							flush_q <= 1'b1;
							end_q   <= count_q;
							k_q     <= count_q;
						end else begin
							head_q  <= '0;
							count_q <= '0;
						end
					end
				end
				default: flush_q <= flush_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 9'(MAX_BUDGET) + 9'd1)
		else $error("window count beyond depth");
	a_idle_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == E_IDLE && $past(state_q) != E_IDLE |-> count_q <= budget)
		else $error("window left over budget");
	a_search_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == E_SRCH_RD |-> idx_q > 9'd1)
		else $error("search index below two");
	a_trim_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == E_TRIM_RD |-> k_q != 9'd0 && k_q <= count_q)
		else $error("trim index outside window");
endmodule

/* rtl/codepoint_window_text_chunker.sv */
// Top level of the codepoint window text chunker.
// Usage:
//   text_in carries one UTF-8 byte per beat with end_of_text on the last byte.
//   chunk_out carries results: byte offsets of a chunk, a bare end marker or an
//   error code; final_result marks the last result of a text.
//   cfg writes cp_limit (reset 64); write it only while the block idles.
// Operation:
//   A byte that appends a codepoint without overflow passes the event and
//   last-check states; a dropped or error byte passes only the event state.
//   The end-of-text flush trims trailing spaces one entry at a time.
//   An overflow runs a backward break search over the window in the engine
//   (up to budget minus one entries, skipped for a budget of one), then trims
//   trailing spaces and pops leading spaces one entry at a time. All work shares
//   one ring memory read port, which sets the rate.
//   Results reach chunk_out in the cycle after the engine produces them.
// Reset clears all text state and the result queue; the window memory needs
//   no clearing. A stalled receiver holds results in a four-deep queue;
//   input is taken again only while at least two slots are free.
`timescale 1ns / 1ps
module codepoint_window_text_chunker (
	input  logic       clk,
	input  logic       arst_n,
	cwtc_in_if.sink    text_in,
	cwtc_out_if.source chunk_out,
	cwtc_cfg_if.sink   cfg
);
	import cwtc_pkg::*;

	logic [8:0] budget_q;
	logic       accept, eng_idle, push;
	logic [2:0] oq_count;
	ev_t        ev;
	res_t       push_res;

	assign cfg.ready     = 1'b1;
	assign text_in.ready = eng_idle && oq_count <= 3'(OQ_DEPTH - 2);
	assign accept        = text_in.valid && text_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) budget_q <= 9'(BUDGET_RESET);
		else if (cfg.valid) budget_q <= cfg.cp_limit;
	end

	cwtc_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.text_byte   (text_in.text_byte),
		.end_of_text (text_in.end_of_text),
		.ev          (ev)
	);

	cwtc_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.ev_in      (ev),
		.budget_cfg (budget_q),
		.idle       (eng_idle),
		.push       (push),
		.push_res   (push_res)
	);

	cwtc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (push_res),
		.count     (oq_count),
		.chunk_out (chunk_out)
	);

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !eng_idle)
		else $error("engine did not start on accepted beat");
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> oq_count <= 3'(OQ_DEPTH - 2))
		else $error("beat accepted without queue room");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!eng_idle |-> !text_in.ready)
		else $error("input ready while engine busy");
endmodule
